FILE: hw/rtl/debug_link_packet_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debug link packet receiver checker
// ----------------------------------------------------------------------------
`ifndef DEBUG_LINK_PACKET_RECEIVER_MACROS_SVH
`define DEBUG_LINK_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DLPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dlpr assertion failed");

// next-cycle implication, disabled while reset is held
`define DLPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dlpr assertion failed");

`endif

FILE: hw/rtl/dlpr_pkg.sv
// ----------------------------------------------------------------------------
// dlpr_pkg
// Shared types and constants of the debug link packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpr_pkg;

    localparam int MaxPacket = 4096;
    localparam int CntW      = $clog2(MaxPacket + 1);

    localparam logic [7:0] CharDollar = 8'h24;
    localparam logic [7:0] CharHash   = 8'h23;
    localparam logic [7:0] CharPlus   = 8'h2B;
    localparam logic [7:0] CharMinus  = 8'h2D;

    localparam logic CmdByte   = 1'b0;
    localparam logic CmdTxDone = 1'b1;

    typedef enum logic [3:0] {
        KIND_PAYLOAD    = 4'd0,
        KIND_ACCEPTED   = 4'd1,
        KIND_MISMATCH   = 4'd2,
        KIND_BAD_DIGIT  = 4'd3,
        KIND_DROPPED    = 4'd4,
        KIND_ACKED      = 4'd5,
        KIND_RESEND     = 4'd6,
        KIND_STRAY_ACK  = 4'd7,
        KIND_UNEXPECTED = 4'd8
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        payload_byte;
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic [CntW-1:0]   payload_length;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/debug_link_packet_receiver.sv
// ----------------------------------------------------------------------------
// debug_link_packet_receiver
// Receive side of a '$payload#hh' debug link with checksum and ack tracking.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one transfer per link byte (i_cmd = 0) or a
// transmit-done notice (i_cmd = 1). Output channel (o_valid/i_ready): at most
// one result per input transfer, with outcome kind, passed-on payload byte,
// the ack byte to send ('+' or '-') and the finished packet's length.
// Items that give no result ('$', '#', first checksum digit, transmit done)
// still update state but produce no output transfer.
// A result appears on o_valid after its input transfer has passed the input
// register, then the result register. Throughput: one item per cycle while
// the result register is free, set by the state update between registers.
// Reset (synchronous, active low) returns the framer to idle, the response
// stage to none, and empties both registers.
// When the receiver holds i_ready low, the result stays put; one more input
// is still taken into the input register, then o_ready drops until the
// result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module debug_link_packet_receiver (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_cmd,
    input  wire logic [7:0]                 i_link_byte,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [3:0]                      o_outcome_kind,
    output logic [7:0]                      o_payload_byte,
    output logic                            o_tx_valid,
    output logic [7:0]                      o_tx_byte,
    output logic [dlpr_pkg::CntW-1:0]       o_payload_length
);

    logic              w_in_vld;
    logic              w_in_cmd;
    logic [7:0]        w_in_byte;
    logic              w_advance;
    logic              w_out_free;
    logic              w_res_vld;
    dlpr_pkg::t_result w_res;
    dlpr_pkg::t_result w_out_res;

    assign w_advance = w_in_vld && w_out_free;

    dlpr_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_link_byte (i_link_byte),
        .i_advance   (w_advance),
        .o_vld       (w_in_vld),
        .o_cmd       (w_in_cmd),
        .o_byte      (w_in_byte)
    );

    dlpr_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_cmd     (w_in_cmd),
        .i_byte    (w_in_byte),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    dlpr_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_advance),
        .i_res_vld (w_res_vld),
        .i_res     (w_res),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_free    (w_out_free),
        .o_res     (w_out_res)
    );

    assign o_outcome_kind   = w_out_res.kind;
    assign o_payload_byte   = w_out_res.payload_byte;
    assign o_tx_valid       = w_out_res.tx_valid;
    assign o_tx_byte        = w_out_res.tx_byte;
    assign o_payload_length = w_out_res.payload_length;

endmodule

`default_nettype wire

FILE: hw/rtl/dlpr_in_reg.sv
// ----------------------------------------------------------------------------
// dlpr_in_reg
// Input register: holds one link transfer until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpr_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_link_byte,
    input  wire logic       i_advance,
    output logic            o_vld,
    output logic            o_cmd,
    output logic [7:0]      o_byte
);

    logic       r_vld;
    logic       r_cmd;
    logic [7:0] r_byte;

    // room whenever empty or the held item moves on this cycle
    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd  <= i_cmd;
            r_byte <= i_link_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_cmd  = r_cmd;
    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: hw/rtl/dlpr_engine.sv
// ----------------------------------------------------------------------------
// dlpr_engine
// Framing state, checksum and response tracking; one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpr_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_byte,
    output logic             o_res_vld,
    output dlpr_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DIGIT1  = 2'd2,
        PH_DIGIT2  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_READY = 2'd1,
        ST_SENT  = 2'd2
    } t_stage;

    t_phase                     r_phase,   n_phase;
    t_stage                     r_stage,   n_stage;
    logic [7:0]                 r_sum,     n_sum;
    logic [3:0]                 r_high,    n_high;
    logic                       r_first,   n_first;
    logic [dlpr_pkg::CntW-1:0]  r_cnt,     n_cnt;

    logic       b_hex_ok;
    logic [3:0] b_hex_val;

    // lowercase hex only; uppercase is a bad digit
    always_comb begin
        b_hex_ok  = 1'b0;
        b_hex_val = 4'd0;
        if (i_byte inside {[8'h61:8'h66]}) begin
            b_hex_ok  = 1'b1;
            b_hex_val = i_byte[3:0] + 4'd9;
        end else if (i_byte inside {[8'h30:8'h39]}) begin
            b_hex_ok  = 1'b1;
            b_hex_val = i_byte[3:0];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_stage   = r_stage;
        n_sum     = r_sum;
        n_high    = r_high;
        n_first   = r_first;
        n_cnt     = r_cnt;
        o_res_vld = 1'b0;
        o_res     = '0;

        if (i_cmd == dlpr_pkg::CmdTxDone) begin
            if (r_stage == ST_READY) begin
                n_stage = ST_SENT;
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == dlpr_pkg::CharDollar) begin
                        n_sum   = 8'd0;
                        n_cnt   = '0;
                        n_phase = PH_PAYLOAD;
                    end else if (i_byte == dlpr_pkg::CharPlus ||
                                 i_byte == dlpr_pkg::CharMinus) begin
                        o_res_vld = 1'b1;
                        if (r_stage == ST_SENT) begin
                            if (i_byte == dlpr_pkg::CharPlus) begin
                                n_stage    = ST_NONE;
                                o_res.kind = dlpr_pkg::KIND_ACKED;
                            end else begin
                                n_stage    = ST_READY;
                                o_res.kind = dlpr_pkg::KIND_RESEND;
                            end
                        end else begin
                            o_res.kind = dlpr_pkg::KIND_STRAY_ACK;
                        end
                    end else begin
                        o_res_vld  = 1'b1;
                        o_res.kind = dlpr_pkg::KIND_UNEXPECTED;
                    end
                end
                PH_PAYLOAD: begin
                    if (i_byte == dlpr_pkg::CharHash) begin
                        n_phase = PH_DIGIT1;
                    end else begin
                        n_sum = r_sum + i_byte;
                        if (r_cnt < dlpr_pkg::CntW'(dlpr_pkg::MaxPacket)) begin
                            n_cnt = r_cnt + dlpr_pkg::CntW'(1);
                        end
                        o_res_vld          = 1'b1;
                        o_res.kind         = dlpr_pkg::KIND_PAYLOAD;
                        o_res.payload_byte = i_byte;
                    end
                end
                PH_DIGIT1: begin
                    n_first = b_hex_ok;
                    n_high  = b_hex_val;
                    n_phase = PH_DIGIT2;
                end
                PH_DIGIT2: begin
                    n_phase              = PH_IDLE;
                    o_res_vld            = 1'b1;
                    o_res.payload_length = r_cnt;
                    if (r_stage != ST_NONE) begin
                        o_res.kind = dlpr_pkg::KIND_DROPPED;
                    end else if (!r_first || !b_hex_ok) begin
                        o_res.kind     = dlpr_pkg::KIND_BAD_DIGIT;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = dlpr_pkg::CharMinus;
                    end else if ({r_high, b_hex_val} != r_sum) begin
                        o_res.kind     = dlpr_pkg::KIND_MISMATCH;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = dlpr_pkg::CharMinus;
                    end else begin
                        n_stage        = ST_READY;
                        o_res.kind     = dlpr_pkg::KIND_ACCEPTED;
                        o_res.tx_valid = 1'b1;
                        o_res.tx_byte  = dlpr_pkg::CharPlus;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_stage <= ST_NONE;
            r_sum   <= 8'd0;
            r_high  <= 4'd0;
            r_first <= 1'b0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_sum   <= n_sum;
            r_high  <= n_high;
            r_first <= n_first;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dlpr_out_reg.sv
// ----------------------------------------------------------------------------
// dlpr_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpr_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_res_vld,
    input  wire dlpr_pkg::t_result i_res,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic                   o_free,
    output dlpr_pkg::t_result      o_res
);

    logic              r_vld;
    dlpr_pkg::t_result r_res;

    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_res_vld;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: hw/rtl/dlpr_checker.sv
// ----------------------------------------------------------------------------
// dlpr_checker
// Port-level checks on the debug link packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debug_link_packet_receiver_macros.svh"

module dlpr_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic [3:0]                 o_outcome_kind,
    input  wire logic [7:0]                 o_payload_byte,
    input  wire logic                       o_tx_valid,
    input  wire logic [7:0]                 o_tx_byte,
    input  wire logic [dlpr_pkg::CntW-1:0]  o_payload_length
);

    logic                         w_verdict;
    logic                         w_accepted;
    logic                         w_plus_ack;
    logic                         w_len_ok;
    logic                         w_not_payload;
    logic [dlpr_pkg::CntW+20:0]   w_out_sig;

    assign w_verdict     = (o_outcome_kind == dlpr_pkg::KIND_ACCEPTED) ||
                           (o_outcome_kind == dlpr_pkg::KIND_MISMATCH) ||
                           (o_outcome_kind == dlpr_pkg::KIND_BAD_DIGIT);
    assign w_accepted    = (o_outcome_kind == dlpr_pkg::KIND_ACCEPTED);
    assign w_plus_ack    = o_tx_valid && (o_tx_byte == dlpr_pkg::CharPlus);
    assign w_len_ok      = (o_payload_length <= dlpr_pkg::CntW'(dlpr_pkg::MaxPacket));
    assign w_not_payload = (o_outcome_kind != dlpr_pkg::KIND_PAYLOAD);
    assign w_out_sig     = {o_outcome_kind, o_payload_byte, o_tx_valid, o_tx_byte,
                            o_payload_length};

    // only packet verdicts drive an ack byte
    `DLPR_ASSERT_NOW(a_tx_only_verdict, o_valid && o_tx_valid, w_verdict)

    // accepted packet is acked with '+'; the '-' for rejects is not asserted
    `DLPR_ASSERT_NOW(a_ack_byte, o_valid && w_accepted, w_plus_ack)

    // length saturates
    `DLPR_ASSERT_NOW(a_len_sat, o_valid, w_len_ok)

    // payload byte field is clear outside payload transfers
    `DLPR_ASSERT_NOW(a_pbyte_clear, o_valid && w_not_payload, o_payload_byte == 8'd0)

    // stalled result holds
    `DLPR_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(w_out_sig))

endmodule

bind debug_link_packet_receiver dlpr_checker u_dlpr_checker (.*);

`default_nettype wire

FILE: test/tb_debug_link_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debug_link_packet_receiver
// Drives link bytes and transmit-done notices into the packet receiver, with
// random gaps on both channels and one long output hold-off. A scoreboard
// predicts framing, checksum and response-stage behavior per input transfer
// and checks every output transfer against it in order.
// ----------------------------------------------------------------------------

module tb_debug_link_packet_receiver;

    localparam int ClkHalf      = 5;
    localparam int StallLimit   = 1000;
    localparam int RandomItems  = 850;
    localparam int QuietFrom    = 300;
    localparam int QuietTo      = 500;
    localparam int HoldFrom     = 800;
    localparam int HoldCycles   = 80;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_PAYLOAD,
        RX_DIGIT_HI,
        RX_DIGIT_LO
    } t_rx_phase;

    typedef enum logic [1:0] {
        RESP_NONE,
        RESP_READY,
        RESP_SENT
    } t_resp_stage;

    // checksum digit variants of a generated packet
    typedef enum int {
        SUM_GOOD,
        SUM_WRONG,
        SUM_UPPER,
        SUM_JUNK
    } t_sum_mode;

    class link_scoreboard;
        dlpr_pkg::t_result         pending_outcomes[$];
        int                        errors;
        t_rx_phase                 phase;
        t_resp_stage               stage;
        logic [7:0]                sum;
        logic [3:0]                hi_nib;
        logic                      hi_ok;
        logic [dlpr_pkg::CntW-1:0] count;

        function new();
            errors = 0;
            phase  = RX_IDLE;
            stage  = RESP_NONE;
            sum    = '0;
            hi_nib = '0;
            hi_ok  = 1'b0;
            count  = '0;
        endfunction

        function bit is_lower_hex(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h30 && c <= 8'h39);
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] c);
            if (c >= 8'h61 && c <= 8'h66)
                return 4'(c - 8'h61 + 8'd10);
            if (c >= 8'h30 && c <= 8'h39)
                return 4'(c - 8'h30);
            return 4'd0;
        endfunction

        function void note_transfer(logic cmd, logic [7:0] b);
            dlpr_pkg::t_result r;
            bit                has_result;
            r = '0;
            has_result = 1'b1;
            if (cmd == dlpr_pkg::CmdTxDone) begin
                if (stage == RESP_READY)
                    stage = RESP_SENT;
                return;
            end
            case (phase)
                RX_IDLE: begin
                    if (b == dlpr_pkg::CharDollar) begin
                        sum = '0;
                        count = '0;
                        phase = RX_PAYLOAD;
                        has_result = 1'b0;
                    end else if (b == dlpr_pkg::CharPlus || b == dlpr_pkg::CharMinus) begin
                        if (stage == RESP_SENT) begin
                            stage  = (b == dlpr_pkg::CharPlus) ? RESP_NONE : RESP_READY;
                            r.kind = (b == dlpr_pkg::CharPlus) ? dlpr_pkg::KIND_ACKED :
                                                                 dlpr_pkg::KIND_RESEND;
                        end else begin
                            r.kind = dlpr_pkg::KIND_STRAY_ACK;
                        end
                    end else begin
                        r.kind = dlpr_pkg::KIND_UNEXPECTED;
                    end
                end
                RX_PAYLOAD: begin
                    if (b == dlpr_pkg::CharHash) begin
                        phase = RX_DIGIT_HI;
                        has_result = 1'b0;
                    end else begin
                        sum = sum + b;
                        if (count < dlpr_pkg::MaxPacket)
                            count = count + 1'b1;
                        r.kind = dlpr_pkg::KIND_PAYLOAD;
                        r.payload_byte = b;
                    end
                end
                RX_DIGIT_HI: begin
                    hi_ok  = is_lower_hex(b);
                    hi_nib = hex_nibble(b);
                    phase  = RX_DIGIT_LO;
                    has_result = 1'b0;
                end
                default: begin
                    phase = RX_IDLE;
                    r.payload_length = count;
                    if (stage != RESP_NONE) begin
                        r.kind = dlpr_pkg::KIND_DROPPED;
                    end else begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = dlpr_pkg::CharMinus;
                        if (!hi_ok || !is_lower_hex(b))
                            r.kind = dlpr_pkg::KIND_BAD_DIGIT;
                        else if ({hi_nib, hex_nibble(b)} != sum)
                            r.kind = dlpr_pkg::KIND_MISMATCH;
                        else begin
                            r.kind    = dlpr_pkg::KIND_ACCEPTED;
                            r.tx_byte = dlpr_pkg::CharPlus;
                            stage     = RESP_READY;
                        end
                    end
                end
            endcase
            if (has_result)
                pending_outcomes = {pending_outcomes, r};
        endfunction

        function void check_outcome(logic [3:0] kind, logic [7:0] pbyte, logic txv,
                                    logic [7:0] txb, logic [dlpr_pkg::CntW-1:0] len);
            dlpr_pkg::t_result e;
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d", kind);
                errors++;
                return;
            end
            e = pending_outcomes.pop_front();
            if (kind !== e.kind) begin
                $error("outcome_kind: expected %0d, got %0d", e.kind, kind);
                errors++;
            end
            if (pbyte !== e.payload_byte) begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", e.payload_byte, pbyte);
                errors++;
            end
            if (txv !== e.tx_valid) begin
                $error("tx_valid: expected %0b, got %0b", e.tx_valid, txv);
                errors++;
            end
            if (txb !== e.tx_byte) begin
                $error("tx_byte: expected 0x%02h, got 0x%02h", e.tx_byte, txb);
                errors++;
            end
            if (len !== e.payload_length) begin
                $error("payload_length: expected %0d, got %0d", e.payload_length, len);
                errors++;
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_cmd;
    logic [7:0]                i_link_byte;
    logic                      o_valid;
    logic                      i_ready;
    logic [3:0]                o_outcome_kind;
    logic [7:0]                o_payload_byte;
    logic                      o_tx_valid;
    logic [7:0]                o_tx_byte;
    logic [dlpr_pkg::CntW-1:0] o_payload_length;

    link_scoreboard sb;
    int             cyc;
    bit             quiet;

    debug_link_packet_receiver uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_link_byte     (i_link_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_outcome_kind  (o_outcome_kind),
        .o_payload_byte  (o_payload_byte),
        .o_tx_valid      (o_tx_valid),
        .o_tx_byte       (o_tx_byte),
        .o_payload_length(o_payload_length)
    );

    initial i_clk = 1'b0;
    always #(ClkHalf) i_clk = ~i_clk;

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = dlpr_pkg::CmdByte;
        i_link_byte = 8'h00;
        i_ready     = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= i_rst_n ? cyc + 1 : 0;
    end

    assign quiet = (cyc >= QuietFrom && cyc < QuietTo);

    // result side: random stalls plus one long hold-off so the block backs up
    initial begin : result_sink
        int held;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cyc >= HoldFrom && held < HoldCycles) begin
                held++;
                i_ready = 1'b0;
            end else begin
                i_ready = quiet || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_outcome(o_outcome_kind, o_payload_byte, o_tx_valid, o_tx_byte,
                             o_payload_length);
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < StallLimit) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 26) begin
            i_valid     = 1'b0;
            i_cmd       = 1'($urandom);
            i_link_byte = 8'($urandom);
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_cmd       = cmd;
        i_link_byte = b;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_transfer(cmd, b);
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(dlpr_pkg::CmdByte, b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + nib : 8'h61 + nib - 8'd10;
    endfunction

    task automatic send_packet(input int len, input t_sum_mode mode);
        logic [7:0] b;
        logic [7:0] chk;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        chk = '0;
        send_byte(dlpr_pkg::CharDollar);
        for (int n = 0; n < len; n++) begin
            do
                b = 8'($urandom);
            while (b == dlpr_pkg::CharHash);
            chk = chk + b;
            send_byte(b);
        end
        send_byte(dlpr_pkg::CharHash);
        if (mode == SUM_WRONG)
            chk = chk + 8'($urandom_range(1, 255));
        hi_c = hex_char(chk[7:4]);
        lo_c = hex_char(chk[3:0]);
        if (mode == SUM_UPPER) begin
            if ($urandom_range(0, 1))
                hi_c = 8'h41 + 8'($urandom_range(0, 5));
            else
                lo_c = 8'h41 + 8'($urandom_range(0, 5));
        end else if (mode == SUM_JUNK) begin
            hi_c = 8'($urandom);
            lo_c = 8'($urandom);
        end
        send_byte(hi_c);
        send_byte(lo_c);
    endtask

    task automatic run_random(input int n_items);
        int        done_items;
        int        pick;
        t_sum_mode mode;
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                mode = (pick < 70) ? SUM_GOOD : (pick < 80) ? SUM_WRONG :
                       (pick < 90) ? SUM_UPPER : SUM_JUNK;
                pick = $urandom_range(0, 12);
                send_packet(pick, mode);
                done_items += pick + 4;
            end else if (pick < 65) begin
                send_item(dlpr_pkg::CmdTxDone, 8'($urandom));
                done_items++;
            end else if (pick < 85) begin
                send_byte($urandom_range(0, 1) ? dlpr_pkg::CharPlus : dlpr_pkg::CharMinus);
                done_items++;
            end else begin
                send_item(1'($urandom), 8'($urandom));
                done_items++;
            end
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // stray ack, unexpected byte and an ignored transmit-done after reset
        send_byte(dlpr_pkg::CharPlus);
        send_byte(8'h00);
        send_item(dlpr_pkg::CmdTxDone, 8'hFF);
        // empty packet with a good checksum
        send_byte(dlpr_pkg::CharDollar);
        send_byte(dlpr_pkg::CharHash);
        send_byte(8'h30);
        send_byte(8'h30);
        // ack while the response is only ready is stray
        send_byte(dlpr_pkg::CharMinus);
        // full response cycle: sent, nack, sent again, ack
        send_item(dlpr_pkg::CmdTxDone, 8'h00);
        send_byte(dlpr_pkg::CharMinus);
        send_item(dlpr_pkg::CmdTxDone, 8'h00);
        send_byte(dlpr_pkg::CharPlus);
        // '$' inside payload, uppercase checksum digits
        send_byte(dlpr_pkg::CharDollar);
        send_byte(dlpr_pkg::CharDollar);
        send_byte(8'hFF);
        send_byte(dlpr_pkg::CharHash);
        send_byte(8'h32);
        send_byte(8'h33);
        send_byte(dlpr_pkg::CharDollar);
        send_byte(8'hFF);
        send_byte(dlpr_pkg::CharHash);
        send_byte(8'h46);
        send_byte(8'h46);
        // dropped while the accepted packet above still awaits its response
        send_byte(dlpr_pkg::CharDollar);
        send_byte(dlpr_pkg::CharHash);
        send_byte(8'h30);
        send_byte(8'h31);

        run_random(RandomItems / 2);
        run_random(RandomItems - RandomItems / 2);

        i_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dlpr_pkg.sv
hw/rtl/dlpr_in_reg.sv
hw/rtl/dlpr_engine.sv
hw/rtl/dlpr_out_reg.sv
hw/rtl/debug_link_packet_receiver.sv
hw/rtl/dlpr_checker.sv
test/tb_debug_link_packet_receiver.sv
